// File: rtl/iffi_pkg.sv
package iffi_pkg;

    // Channel layout of one frame
    localparam int NCH        = 9;
    localparam int NGYRO      = 3;
    localparam int GYRO_BASE  = 3;
    localparam int FRAME_LEN  = 18;

    // Frame delimiter: 'E','B','S' followed by 0x01
    localparam logic [23:0] DELIM_HEAD = 24'h454253;
    localparam logic [7:0]  DELIM_TAIL = 8'h01;
    localparam logic [4:0]  COUNT_MAX  = 5'd31;
    localparam logic [4:0]  DELIM_LEN  = 5'd3;

    // Result queue
    localparam int QDEPTH = 4;
    localparam int QIDX_W = 2;
    localparam int QCNT_W = 3;

    // Register reset values
    localparam logic [10:0] RST_OFFSET_X = 11'h7EE;   // -18
    localparam logic [10:0] RST_OFFSET_Y = 11'd16;
    localparam logic [10:0] RST_OFFSET_Z = 11'd40;
    localparam logic [14:0] RST_DEAD_BAND = 15'd50;
    localparam logic [31:0] RST_ANGLE_GAIN = 32'd2061584;

    // Register indexes on the configuration port
    typedef enum logic [2:0] {
        CFG_GYRO_OFFSET_X = 3'd0,
        CFG_GYRO_OFFSET_Y = 3'd1,
        CFG_GYRO_OFFSET_Z = 3'd2,
        CFG_DEAD_BAND     = 3'd3,
        CFG_ANGLE_GAIN    = 3'd4
    } t_cfg_idx;

    typedef logic signed [15:0] t_sample;
    typedef t_sample t_sample_vec [NCH];
    typedef logic signed [31:0] t_angle;

    // One finished result as held in the output queue
    typedef struct {
        t_sample avg   [NCH];
        t_angle  angle [NGYRO];
    } t_result;

endpackage

// File: rtl/iffi_window.sv
module iffi_window #(
    parameter int WINDOW_DEPTH = 10
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  iffi_pkg::t_sample    i_val [iffi_pkg::NCH],
    output logic                 o_valid,
    output iffi_pkg::t_sample    o_avg [iffi_pkg::NCH]
);

    localparam int SUM_W = $clog2(WINDOW_DEPTH) + 16;
    localparam int PTR_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int ROW_W = iffi_pkg::NCH * 16;
    localparam logic signed [SUM_W:0] DEPTH_S = (SUM_W + 1)'(WINDOW_DEPTH);

    // History rows, one per frame in the window
    logic [ROW_W-1:0]        mem [WINDOW_DEPTH];
    logic [WINDOW_DEPTH-1:0] r_hvalid;
    logic [ROW_W-1:0]        r_rd_row;
    logic                    r_rd_ok;
    logic [PTR_W-1:0]        r_ptr;
    logic [PTR_W-1:0]        r_row;
    logic                    r_v_a;
    logic                    r_v_b;
    logic                    r_v_c;
    logic [ROW_W-1:0]        r_val;
    logic signed [SUM_W-1:0] r_sum [iffi_pkg::NCH];
    iffi_pkg::t_sample       r_avg [iffi_pkg::NCH];
    logic [PTR_W-1:0]        n_ptr;
    logic [ROW_W-1:0]        n_val;

    always_comb begin
        n_ptr = (r_ptr == PTR_W'(WINDOW_DEPTH - 1)) ? '0 : r_ptr + 1'b1;
        for (int k = 0; k < iffi_pkg::NCH; k++) begin
            n_val[k*16 +: 16] = i_val[k];
        end
    end

    // Stage A: fetch the oldest row, advance the pointer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_a <= 1'b0;
            r_ptr <= '0;
        end else begin
            r_v_a <= i_valid;
            if (i_valid) begin
                r_ptr <= n_ptr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid) begin
            r_rd_row <= mem[r_ptr];
            r_rd_ok  <= r_hvalid[r_ptr];
            r_row    <= r_ptr;
            r_val    <= n_val;
        end
    end

    // Stage B: replace the oldest row, update running sums
    always_ff @(posedge i_clk) begin
        if (r_v_a) begin
            mem[r_row] <= r_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_b    <= 1'b0;
            r_hvalid <= '0;
            for (int k = 0; k < iffi_pkg::NCH; k++) begin
                r_sum[k] <= '0;
            end
        end else begin
            r_v_b <= r_v_a;
            if (r_v_a) begin
                r_hvalid[r_row] <= 1'b1;
                for (int k = 0; k < iffi_pkg::NCH; k++) begin
                    r_sum[k] <= r_sum[k]
                        + SUM_W'($signed(r_val[k*16 +: 16]))
                        - (r_rd_ok ? SUM_W'($signed(r_rd_row[k*16 +: 16])) : '0);
                end
            end
        end
    end

    // Stage C: average, truncated toward zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_c <= 1'b0;
        end else begin
            r_v_c <= r_v_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_v_b) begin
            for (int k = 0; k < iffi_pkg::NCH; k++) begin
                r_avg[k] <= 16'(($signed({r_sum[k][SUM_W-1], r_sum[k]}) / DEPTH_S));
            end
        end
    end

    assign o_valid = r_v_c;
    assign o_avg   = r_avg;

    // Frames are at least four input bytes apart, so stages never overlap
    a_spacing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> !r_v_a && !r_v_b)
        else $error("window: frame entered while previous frame in stage A/B");

    a_row_marked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v_a |=> r_hvalid[$past(r_row)])
        else $error("window: written row not marked valid");

endmodule

// File: rtl/imu_frame_filter_integrator.sv
// Channel   Dir  Handshake                 Payload
// in        in   i_in_valid / o_in_ready   i_in_byte
// out       out  o_out_valid / i_out_ready o_avg_*, o_angle_x/y/z
// cfg       in   i_cfg_we (no wait)        i_cfg_idx, i_cfg_data
//
// One byte is taken per cycle while o_in_ready is high. A delimiter beat
// yields one result through decode, gyro filter, history update, average,
// gain multiply and accumulate stages, into a 4-entry result queue.
// o_in_ready drops only while the queue plus frames in flight fill 4 slots.
// Reset is synchronous; the history store reads as zero through per-row
// valid bits, so no clearing pass follows reset.
module imu_frame_filter_integrator #(
    parameter int WINDOW_DEPTH = 10
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_in_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic signed [15:0] o_avg_ch0,
    output logic signed [15:0] o_avg_ch1,
    output logic signed [15:0] o_avg_ch2,
    output logic signed [15:0] o_avg_gyro_x,
    output logic signed [15:0] o_avg_gyro_y,
    output logic signed [15:0] o_avg_gyro_z,
    output logic signed [15:0] o_avg_accel_x,
    output logic signed [15:0] o_avg_accel_y,
    output logic signed [15:0] o_avg_accel_z,
    output logic signed [31:0] o_angle_x,
    output logic signed [31:0] o_angle_y,
    output logic signed [31:0] o_angle_z,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data
);

    // Drift offset then deadband on one gyro channel
    function automatic iffi_pkg::t_sample gyro_filter(iffi_pkg::t_sample v,
                                                      logic signed [10:0] off,
                                                      logic [14:0] db);
        logic signed [16:0] s;
        logic signed [16:0] w;
        logic signed [16:0] d;
        s = 17'(v) + 17'(off);
        w = (s > -17'sd32768 && s < 17'sd32767) ? s : 17'(v);
        d = $signed({2'b00, db});
        if (w > -d && w < d) begin
            w = '0;
        end
        return $signed(w[15:0]);
    endfunction

    // Configuration registers
    logic signed [10:0] r_off [iffi_pkg::NGYRO];
    logic [14:0]        r_dead_band;
    logic [31:0]        r_gain;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_off[0]    <= iffi_pkg::RST_OFFSET_X;
            r_off[1]    <= iffi_pkg::RST_OFFSET_Y;
            r_off[2]    <= iffi_pkg::RST_OFFSET_Z;
            r_dead_band <= iffi_pkg::RST_DEAD_BAND;
            r_gain      <= iffi_pkg::RST_ANGLE_GAIN;
        end else if (i_cfg_we) begin
            unique case (iffi_pkg::t_cfg_idx'(i_cfg_idx))
                iffi_pkg::CFG_GYRO_OFFSET_X: r_off[0] <= i_cfg_data[10:0];
                iffi_pkg::CFG_GYRO_OFFSET_Y: r_off[1] <= i_cfg_data[10:0];
                iffi_pkg::CFG_GYRO_OFFSET_Z: r_off[2] <= i_cfg_data[10:0];
                iffi_pkg::CFG_DEAD_BAND:     r_dead_band <= i_cfg_data[14:0];
                iffi_pkg::CFG_ANGLE_GAIN:    r_gain <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Byte framing state
    logic [23:0] r_recent;
    logic [4:0]  r_count;
    logic [7:0]  r_fb [iffi_pkg::FRAME_LEN];
    logic        in_acc;
    logic        is_delim;
    logic        delim_acc;
    logic [4:0]  frame_len;
    iffi_pkg::t_sample n_raw [iffi_pkg::NCH];

    assign in_acc    = i_in_valid && o_in_ready;
    assign is_delim  = (i_in_byte == iffi_pkg::DELIM_TAIL)
                    && (r_recent == iffi_pkg::DELIM_HEAD);
    assign delim_acc = in_acc && is_delim;
    assign frame_len = (r_count >= iffi_pkg::DELIM_LEN) ? r_count - iffi_pkg::DELIM_LEN : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_recent <= '0;
            r_count  <= '0;
        end else if (in_acc) begin
            if (is_delim) begin
                r_recent <= '0;
                r_count  <= '0;
            end else begin
                r_recent <= {r_recent[15:0], i_in_byte};
                if (r_count != iffi_pkg::COUNT_MAX) begin
                    r_count <= r_count + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < iffi_pkg::FRAME_LEN; i++) begin
            if (in_acc && !is_delim && r_count == 5'(i)) begin
                r_fb[i] <= i_in_byte;
            end
        end
    end

    // Decode big-endian words; bytes past the frame read as zero
    always_comb begin
        for (int j = 0; j < iffi_pkg::NCH; j++) begin
            n_raw[j] = $signed({(5'(2*j) < frame_len)     ? r_fb[2*j]     : 8'h00,
                                (5'(2*j + 1) < frame_len) ? r_fb[2*j + 1] : 8'h00});
        end
    end

    // Stage 1: decoded frame
    logic              r_v1;
    iffi_pkg::t_sample r_raw [iffi_pkg::NCH];
    iffi_pkg::t_sample filt  [iffi_pkg::NCH];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= delim_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (delim_acc) begin
            r_raw <= n_raw;
        end
    end

    always_comb begin
        filt = r_raw;
        for (int g = 0; g < iffi_pkg::NGYRO; g++) begin
            filt[iffi_pkg::GYRO_BASE + g] =
                gyro_filter(r_raw[iffi_pkg::GYRO_BASE + g], r_off[g], r_dead_band);
        end
    end

    // Moving average over the history window
    logic              avg_vld;
    iffi_pkg::t_sample avg [iffi_pkg::NCH];

    iffi_window #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_window (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v1),
        .i_val   (filt),
        .o_valid (avg_vld),
        .o_avg   (avg)
    );

    // Stage 5: gyro average times gain
    logic               r_v5;
    iffi_pkg::t_sample  r_avg_d [iffi_pkg::NCH];
    logic signed [48:0] r_prod  [iffi_pkg::NGYRO];
    logic signed [48:0] prod    [iffi_pkg::NGYRO];

    always_comb begin
        for (int g = 0; g < iffi_pkg::NGYRO; g++) begin
            prod[g] = avg[iffi_pkg::GYRO_BASE + g] * $signed({1'b0, r_gain});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v5 <= 1'b0;
        end else begin
            r_v5 <= avg_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (avg_vld) begin
            r_avg_d <= avg;
            r_prod  <= prod;
        end
    end

    // Stage 6: accumulate angles and queue the result
    logic [63:0]       r_acc [iffi_pkg::NGYRO];
    logic [63:0]       n_acc [iffi_pkg::NGYRO];
    iffi_pkg::t_result n_res;

    always_comb begin
        for (int g = 0; g < iffi_pkg::NGYRO; g++) begin
            n_acc[g] = r_acc[g] + 64'(r_prod[g]);
            n_res.angle[g] = $signed(n_acc[g][47:16]);
        end
        n_res.avg = r_avg_d;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int g = 0; g < iffi_pkg::NGYRO; g++) begin
                r_acc[g] <= '0;
            end
        end else if (r_v5) begin
            r_acc <= n_acc;
        end
    end

    // Result queue and flow control
    iffi_pkg::t_result          r_queue [iffi_pkg::QDEPTH];
    logic [iffi_pkg::QIDX_W-1:0] r_head;
    logic [iffi_pkg::QIDX_W-1:0] r_tail;
    logic [iffi_pkg::QCNT_W-1:0] r_qcount;
    logic [1:0]                  r_inflight;
    logic                        q_pop;
    logic [3:0]                  slots_used;

    assign q_pop       = o_out_valid && i_out_ready;
    assign o_out_valid = (r_qcount != '0);
    assign slots_used  = {1'b0, r_qcount} + {2'b00, r_inflight};
    assign o_in_ready  = (slots_used < 4'(iffi_pkg::QDEPTH));

    always_ff @(posedge i_clk) begin
        if (r_v5) begin
            r_queue[r_tail] <= n_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head     <= '0;
            r_tail     <= '0;
            r_qcount   <= '0;
            r_inflight <= '0;
        end else begin
            if (r_v5) begin
                r_tail <= r_tail + 1'b1;
            end
            if (q_pop) begin
                r_head <= r_head + 1'b1;
            end
            r_qcount   <= r_qcount + QCNT_ONE(r_v5) - QCNT_ONE(q_pop);
            r_inflight <= r_inflight + 2'(delim_acc) - 2'(r_v5);
        end
    end

    function automatic logic [iffi_pkg::QCNT_W-1:0] QCNT_ONE(logic b);
        return iffi_pkg::QCNT_W'(b);
    endfunction

    assign o_avg_ch0     = r_queue[r_head].avg[0];
    assign o_avg_ch1     = r_queue[r_head].avg[1];
    assign o_avg_ch2     = r_queue[r_head].avg[2];
    assign o_avg_gyro_x  = r_queue[r_head].avg[3];
    assign o_avg_gyro_y  = r_queue[r_head].avg[4];
    assign o_avg_gyro_z  = r_queue[r_head].avg[5];
    assign o_avg_accel_x = r_queue[r_head].avg[6];
    assign o_avg_accel_y = r_queue[r_head].avg[7];
    assign o_avg_accel_z = r_queue[r_head].avg[8];
    assign o_angle_x     = r_queue[r_head].angle[0];
    assign o_angle_y     = r_queue[r_head].angle[1];
    assign o_angle_z     = r_queue[r_head].angle[2];

    // A finished frame always finds a free queue slot
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v5 |-> (r_qcount != iffi_pkg::QCNT_W'(iffi_pkg::QDEPTH)))
        else $error("result queue overflow");

    // A result only leaves the pipeline for a frame that was counted in
    a_inflight_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v5 |-> (r_inflight != '0))
        else $error("result without a frame in flight");

    // Frame spacing keeps at most two frames in the pipeline
    a_inflight_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_inflight != 2'd3)
        else $error("too many frames in flight");

endmodule

// File: tb/testbench.sv
import iffi_pkg::*;

// Tracks the byte stream, rebuilds each frame and predicts its averages and angles
class imu_frame_checker #(int DEPTH = 10);
    // register copies
    logic [10:0] gyro_offset [NGYRO];
    logic [14:0] dead_band;
    logic [31:0] angle_gain;

    // frame assembly
    logic [23:0] last3;
    logic [7:0]  frame_buf [FRAME_LEN];
    int unsigned nbytes;

    // moving average window and integrators
    t_sample     window [DEPTH][NCH];
    int unsigned slot;
    int          sums [NCH];
    logic [63:0] angle_acc [NGYRO];

    t_result     expected_frames [$];
    int          frames_checked;
    int          errors;

    function new();
        gyro_offset[0] = RST_OFFSET_X;
        gyro_offset[1] = RST_OFFSET_Y;
        gyro_offset[2] = RST_OFFSET_Z;
        dead_band      = RST_DEAD_BAND;
        angle_gain     = RST_ANGLE_GAIN;
        last3          = '0;
        nbytes         = 0;
        slot           = 0;
        frames_checked = 0;
        errors         = 0;
        foreach (frame_buf[i]) frame_buf[i] = '0;
        foreach (window[i, j]) window[i][j] = '0;
        foreach (sums[j]) sums[j] = 0;
        foreach (angle_acc[k]) angle_acc[k] = '0;
    endfunction

    function void set_reg(t_cfg_idx idx, logic [31:0] data);
        case (idx)
            CFG_GYRO_OFFSET_X: gyro_offset[0] = data[10:0];
            CFG_GYRO_OFFSET_Y: gyro_offset[1] = data[10:0];
            CFG_GYRO_OFFSET_Z: gyro_offset[2] = data[10:0];
            CFG_DEAD_BAND:     dead_band = data[14:0];
            CFG_ANGLE_GAIN:    angle_gain = data;
            default: ;
        endcase
    endfunction

    // drift offset unless it would overflow, then the deadband
    function int filter_gyro(int v, logic [10:0] off);
        int s;
        int db;
        s  = v + int'($signed(off));
        db = dead_band;
        if (s > -32768 && s < 32767)
            v = s;
        if (v > -db && v < db)
            v = 0;
        return v;
    endfunction

    function t_result decode_frame(int unsigned len);
        t_result r;
        int      val [NCH];
        logic [7:0] hi;
        logic [7:0] lo;
        t_sample w;
        int      avg;
        longint  inc;
        // big-endian words, missing bytes of a short frame read zero
        for (int j = 0; j < NCH; j++) begin
            hi = (2 * j < len) ? frame_buf[2 * j] : 8'h00;
            lo = (2 * j + 1 < len) ? frame_buf[2 * j + 1] : 8'h00;
            w = {hi, lo};
            val[j] = w;
        end
        for (int k = 0; k < NGYRO; k++)
            val[GYRO_BASE + k] = filter_gyro(val[GYRO_BASE + k], gyro_offset[k]);
        // running sums, average truncated toward zero, gyro averages integrated
        for (int j = 0; j < NCH; j++) begin
            sums[j] += val[j] - int'(window[slot][j]);
            window[slot][j] = t_sample'(val[j]);
            avg = sums[j] / DEPTH;
            r.avg[j] = t_sample'(avg);
            if (j >= GYRO_BASE && j < GYRO_BASE + NGYRO) begin
                inc = longint'(avg) * longint'({32'd0, angle_gain});
                angle_acc[j - GYRO_BASE] += inc;
                r.angle[j - GYRO_BASE] = angle_acc[j - GYRO_BASE][47:16];
            end
        end
        slot = (slot + 1 >= DEPTH) ? 0 : slot + 1;
        return r;
    endfunction

    // one accepted input beat
    function void take_byte(logic [7:0] b);
        if (b == DELIM_TAIL && last3 == DELIM_HEAD) begin
            expected_frames.push_back(decode_frame(nbytes >= 3 ? nbytes - 3 : 0));
            nbytes = 0;
            last3  = '0;
        end else begin
            if (nbytes < FRAME_LEN)
                frame_buf[nbytes] = b;
            if (nbytes < COUNT_MAX)
                nbytes++;
            last3 = {last3[15:0], b};
        end
    endfunction

    task report(string what, longint want, longint got);
        errors++;
        if (errors <= 100)
            $display("frame %0d: %s expected %0d got %0d", frames_checked, what, want, got);
    endtask

    // one accepted output beat against the oldest pending frame
    task check_result(t_result got);
        t_result want;
        if (expected_frames.size() == 0) begin
            report("result with no frame pending", 0, 0);
            return;
        end
        want = expected_frames.pop_front();
        for (int j = 0; j < NCH; j++)
            if (got.avg[j] !== want.avg[j])
                report($sformatf("avg channel %0d", j), want.avg[j], got.avg[j]);
        for (int k = 0; k < NGYRO; k++)
            if (got.angle[k] !== want.angle[k])
                report($sformatf("angle %0d", k), want.angle[k], got.angle[k]);
        frames_checked++;
    endtask
endclass

module testbench;
    localparam int WIN_DEPTH    = 10;
    localparam int PHASE_ITEMS  = 310;
    localparam int HOLD_CYCLES  = 1200;
    localparam int SETTLE_CYCLES = 16;
    localparam int TAIL_CYCLES  = 24;
    localparam int CYCLE_LIMIT  = 400000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [7:0]  i_in_byte = 8'h00;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic signed [15:0] o_avg_ch0, o_avg_ch1, o_avg_ch2;
    logic signed [15:0] o_avg_gyro_x, o_avg_gyro_y, o_avg_gyro_z;
    logic signed [15:0] o_avg_accel_x, o_avg_accel_y, o_avg_accel_z;
    logic signed [31:0] o_angle_x, o_angle_y, o_angle_z;
    logic        i_cfg_we = 1'b0;
    t_cfg_idx    i_cfg_idx = CFG_GYRO_OFFSET_X;
    logic [31:0] i_cfg_data = '0;

    imu_frame_checker #(WIN_DEPTH) chk;

    int items_sent = 0;
    int results_seen = 0;
    int cycles = 0;
    bit hold_active = 1'b0;
    bit send_burst = 1'b0;
    bit recv_burst = 1'b0;

    imu_frame_filter_integrator #(.WINDOW_DEPTH(WIN_DEPTH)) uut (.*);

    always #6 i_clk = ~i_clk;

    // watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles == CYCLE_LIMIT) begin
            $display("** imu_frame_filter_integrator: FAILED **");
            $finish;
        end
    end

    // idle draws, with occasional stretches of back-to-back beats
    function int sender_gap();
        if (hold_active)
            return 0;
        if ($urandom_range(0, 39) == 0)
            send_burst = !send_burst;
        return send_burst ? 0 : $urandom_range(0, 14);
    endfunction

    function int receiver_gap();
        if ($urandom_range(0, 39) == 0)
            recv_burst = !recv_burst;
        return recv_burst ? 0 : $urandom_range(0, 14);
    endfunction

    task send_byte(input logic [7:0] b);
        int gap;
        gap = sender_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_byte  <= b;
        @(posedge i_clk);
        while (o_in_ready !== 1'b1) @(posedge i_clk);
        chk.take_byte(b);
        items_sent++;
    endtask

    task send_delimiter();
        send_byte(DELIM_HEAD[23:16]);
        send_byte(DELIM_HEAD[15:8]);
        send_byte(DELIM_HEAD[7:0]);
        send_byte(DELIM_TAIL);
    endtask

    function logic [7:0] delim_byte();
        case ($urandom_range(0, 3))
            0: return DELIM_HEAD[23:16];
            1: return DELIM_HEAD[15:8];
            2: return DELIM_HEAD[7:0];
            default: return DELIM_TAIL;
        endcase
    endfunction

    // channel word aimed at the offset overflow and deadband edges
    function logic [15:0] pick_word(int ch);
        int off;
        int db;
        int r;
        off = 0;
        db  = 0;
        if (ch >= GYRO_BASE && ch < GYRO_BASE + NGYRO) begin
            off = int'($signed(chk.gyro_offset[ch - GYRO_BASE]));
            db  = chk.dead_band;
        end
        r = $urandom_range(0, 19);
        if (r < 5)
            return 16'($urandom_range(0, 240) - 120);
        if (r < 8)
            return 16'(32767 - off - int'($urandom_range(0, 2)));
        if (r < 10)
            return 16'(-32768 - off + int'($urandom_range(0, 2)));
        if (r < 13)
            return 16'(($urandom_range(0, 1) ? db : -db) - off + int'($urandom_range(0, 2)) - 1);
        return 16'($urandom());
    endfunction

    // a well-formed frame of random length and content
    task send_frame();
        int len;
        int r;
        logic [15:0] w;
        logic [7:0] b;
        logic [7:0] content [$];
        r = $urandom_range(0, 19);
        if (r < 14)
            len = FRAME_LEN;
        else if (r < 17)
            len = $urandom_range(0, FRAME_LEN - 1);
        else
            len = $urandom_range(FRAME_LEN + 1, 34);
        for (int j = 0; j < NCH; j++) begin
            w = pick_word(j);
            content.push_back(w[15:8]);
            content.push_back(w[7:0]);
        end
        while (content.size() < len)
            content.push_back(8'($urandom()));
        for (int i = 0; i < len; i++) begin
            b = content[i];
            if ($urandom_range(0, 19) == 0)
                b = delim_byte();
            send_byte(b);
        end
        send_delimiter();
    endtask

    task send_noise();
        int n;
        n = $urandom_range(1, 10);
        repeat (n) send_byte($urandom_range(0, 1) ? delim_byte() : 8'($urandom()));
    endtask

    // partial or doubled delimiters
    task send_broken();
        case ($urandom_range(0, 3))
            0: begin
                send_byte(DELIM_HEAD[23:16]);
                send_byte(DELIM_HEAD[15:8]);
                send_byte(DELIM_HEAD[7:0]);
                send_byte(8'($urandom_range(2, 255)));
            end
            1: begin
                send_byte(DELIM_HEAD[23:16]);
                send_byte(DELIM_HEAD[15:8]);
                send_byte(DELIM_TAIL);
            end
            2: begin
                send_byte(DELIM_HEAD[23:16]);
                send_delimiter();
            end
            default: begin
                send_byte(DELIM_HEAD[23:16]);
                send_byte(DELIM_HEAD[15:8]);
                send_byte(DELIM_HEAD[7:0]);
                send_delimiter();
            end
        endcase
    endtask

    task send_directed();
        logic [7:0] seq [$];
        // field extremes: gyro x overflows at -32768, gyro y overflows high,
        // gyro z lands exactly on the deadband, accel holds a head without tail
        seq = '{8'h80, 8'h00, 8'h7F, 8'hFF, 8'h00, 8'h01, 8'h80, 8'h00, 8'h7F, 8'hF0,
                8'h00, 8'h0A, 8'hFF, 8'hFF, 8'h45, 8'h42, 8'h53, 8'h00};
        foreach (seq[i]) send_byte(seq[i]);
        send_delimiter();
        // a lone 'E' ahead of the delimiter is the whole frame
        send_byte(DELIM_HEAD[23:16]);
        send_delimiter();
    endtask

    task wait_results_done();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (chk.expected_frames.size() != 0) @(posedge i_clk);
    endtask

    task write_reg(t_cfg_idx idx, logic [31:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        chk.set_reg(idx, data);
    endtask

    task write_all(int ox, int oy, int oz, int db, logic [31:0] gain);
        write_reg(CFG_GYRO_OFFSET_X, 32'(ox));
        write_reg(CFG_GYRO_OFFSET_Y, 32'(oy));
        write_reg(CFG_GYRO_OFFSET_Z, 32'(oz));
        write_reg(CFG_DEAD_BAND, 32'(db));
        write_reg(CFG_ANGLE_GAIN, gain);
        i_cfg_we <= 1'b0;
    endtask

    task load_setting(int p);
        case (p)
            1: write_all(-1024, 1023, 0, 0, 32'hFFFF_FFFF);
            2: write_all(1023, -1024, -1, 32767, 32'd0);
            3: write_all($urandom_range(0, 2047) - 1024, $urandom_range(0, 2047) - 1024,
                         $urandom_range(0, 2047) - 1024, $urandom_range(0, 300), $urandom());
            4: write_all($urandom_range(0, 2047) - 1024, $urandom_range(0, 2047) - 1024,
                         $urandom_range(0, 2047) - 1024, $urandom_range(0, 32767),
                         $urandom_range(0, 32'h0100_0000));
            default: write_all(int'($signed(RST_OFFSET_X)), int'($signed(RST_OFFSET_Y)),
                               int'($signed(RST_OFFSET_Z)), RST_DEAD_BAND, RST_ANGLE_GAIN);
        endcase
    endtask

    // input side: reset, directed frames, then random phases under several settings
    initial begin
        int start;
        int r;
        bit paused;
        chk = new();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        send_directed();
        for (int p = 0; p < 6; p++) begin
            if (p > 0) begin
                wait_results_done();
                repeat (SETTLE_CYCLES) @(posedge i_clk);
                load_setting(p);
            end
            start  = items_sent;
            paused = 1'b0;
            while (items_sent - start < PHASE_ITEMS) begin
                // one pause with the input quiet until every frame is out
                if (p == 1 && !paused && items_sent - start >= PHASE_ITEMS / 2) begin
                    wait_results_done();
                    paused = 1'b1;
                end
                r = $urandom_range(0, 9);
                if (r < 7)
                    send_frame();
                else if (r == 7)
                    send_noise();
                else
                    send_broken();
            end
        end
        wait_results_done();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (chk.errors == 0)
            $display("** imu_frame_filter_integrator: PASSED **");
        else
            $display("** imu_frame_filter_integrator: FAILED **");
        $finish;
    end

    // output side: random stalls, two long hold-offs that back up the block
    initial begin
        t_result got;
        int gap;
        int holds_done;
        holds_done = 0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (holds_done < 2 && results_seen >= (holds_done == 0 ? 10 : 45)) begin
                i_out_ready <= 1'b0;
                hold_active = 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_active = 1'b0;
                holds_done++;
            end
            gap = receiver_gap();
            if (gap > 0) begin
                i_out_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            @(posedge i_clk);
            while (o_out_valid !== 1'b1) @(posedge i_clk);
            got.avg[0]   = o_avg_ch0;
            got.avg[1]   = o_avg_ch1;
            got.avg[2]   = o_avg_ch2;
            got.avg[3]   = o_avg_gyro_x;
            got.avg[4]   = o_avg_gyro_y;
            got.avg[5]   = o_avg_gyro_z;
            got.avg[6]   = o_avg_accel_x;
            got.avg[7]   = o_avg_accel_y;
            got.avg[8]   = o_avg_accel_z;
            got.angle[0] = o_angle_x;
            got.angle[1] = o_angle_y;
            got.angle[2] = o_angle_z;
            chk.check_result(got);
            results_seen++;
        end
    end
endmodule
